### sv/mrg_pkg.sv
// Package for the maze row generator: field widths, controller op codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package mrg_pkg;

  localparam int MAX_COLS_DEF = 32;
  localparam int WALL_W       = 32;
  localparam int LABEL_W      = 6;
  localparam int NUM_LABELS   = 1 << LABEL_W;
  localparam int ROW_W        = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int COLS_W       = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 8'd1;

  // Datapath column ops
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RIGHT = 3'd1;
  localparam logic [2:0] OP_LAST  = 3'd2;
  localparam logic [2:0] OP_COUNT = 3'd3;
  localparam logic [2:0] OP_OPEN  = 3'd4;
  localparam logic [2:0] OP_USED  = 3'd5;
  localparam logic [2:0] OP_RELAB = 3'd6;

  typedef struct packed {
    logic       load;
    logic [2:0] op;
    logic       emit;
  } mrg_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last_row;
    logic out_free;
  } mrg_status_t;

endpackage
`default_nettype wire

### sv/mrg_row_in_if.sv
// Input channel: random bits for one maze row.
// Depends on mrg_pkg.
`default_nettype none
interface mrg_row_in_if import mrg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WALL_W-1:0] right_random;
  logic [WALL_W-1:0] bottom_random;
  modport source (output valid, output right_random, output bottom_random, input ready);
  modport sink   (input valid, input right_random, input bottom_random, output ready);
endinterface
`default_nettype wire

### sv/mrg_row_out_if.sv
// Output channel: wall masks of one maze row.
// Depends on mrg_pkg.
`default_nettype none
interface mrg_row_out_if import mrg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WALL_W-1:0] right_walls;
  logic [WALL_W-1:0] bottom_walls;
  logic [ROW_W-1:0]  row_number;
  logic              maze_done;
  modport source (output valid, output right_walls, output bottom_walls,
                  output row_number, output maze_done, input ready);
  modport sink   (input valid, input right_walls, input bottom_walls,
                  input row_number, input maze_done, output ready);
endinterface
`default_nettype wire

### sv/mrg_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on mrg_pkg.
`default_nettype none
interface mrg_cfg_if import mrg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/mrg_ctrl.sv
// Controller: sequences the column passes of one row and the result beat.
// Depends on mrg_pkg.
`default_nettype none
module mrg_ctrl import mrg_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mrg_status_t                 status,
  input  wire logic [$clog2(MAX_COLS)-1:0] last_col,
  output mrg_cmd_t                         cmd,
  output logic [$clog2(MAX_COLS)-1:0]      col,
  output logic                             in_ready
);
  localparam int CW = $clog2(MAX_COLS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RIGHT = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_OPEN  = 3'd4;
  localparam logic [2:0] S_USED  = 3'd5;
  localparam logic [2:0] S_RELAB = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]    state, state_next;
  logic [CW-1:0] col_next;
  logic          at_end;

  assign at_end   = (col == last_col);
  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    col_next   = col;
    cmd        = '0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (status.in_valid) begin
          cmd.load   = 1'b1;
          col_next   = '0;
          state_next = S_RIGHT;
        end
      end
      S_RIGHT, S_LAST, S_COUNT, S_OPEN, S_USED, S_RELAB: begin
        unique case (state)
          S_RIGHT: cmd.op = OP_RIGHT;
          S_LAST:  cmd.op = OP_LAST;
          S_COUNT: cmd.op = OP_COUNT;
          S_OPEN:  cmd.op = OP_OPEN;
          S_USED:  cmd.op = OP_USED;
          default: cmd.op = OP_RELAB;
        endcase
        if (at_end) begin
          col_next = '0;
          unique case (state)
            S_RIGHT: state_next = status.last_row ? S_LAST : S_COUNT;
            S_COUNT: state_next = S_OPEN;
            S_OPEN:  state_next = S_USED;
            S_USED:  state_next = S_RELAB;
            default: state_next = S_EMIT;
          endcase
        end else begin
          col_next = col + 1'b1;
        end
      end
      default: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
    end
  end
endmodule
`default_nettype wire

### sv/mrg_datapath.sv
// Datapath: column labels, wall masks, label-use map, row counter,
// configuration registers and the output register. Depends on mrg_pkg.
`default_nettype none
module mrg_datapath import mrg_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mrg_cmd_t                    cmd,
  input  wire logic [$clog2(MAX_COLS)-1:0] col,
  input  wire logic                        in_ready,
  output mrg_status_t                      status,
  output logic [$clog2(MAX_COLS)-1:0]      last_col,
  mrg_row_in_if.sink                       in_ch,
  mrg_row_out_if.source                    out_ch,
  mrg_cfg_if.sink                          cfg
);
  localparam int CW = $clog2(MAX_COLS);

  logic [LABEL_W-1:0]    labels [MAX_COLS];
  logic [WALL_W-1:0]     rr, br, rw, bw, all_mask;
  logic [NUM_LABELS-1:0] used;
  logic [ROW_W-1:0]      row_cnt;
  logic [COLS_W-1:0]     cols_cfg;
  logic [ROW_W-1:0]      rows_cfg;
  logic                  out_valid;
  logic [CW:0]           n;
  logic [CW-1:0]         col1;
  logic [LABEL_W-1:0]    lab_j, lab_j1, free_lab;
  logic [MAX_COLS-1:0]   eq_j, eq_j1;
  logic                  other_exists, open_exists, last_row, restart;
  logic [ROW_W:0]        rows_eff;

  // Active column count, clamped to 1..MAX_COLS
  always_comb begin
    if (cols_cfg == '0)                          n = (CW+1)'(1);
    else if ({1'b0, cols_cfg} > (COLS_W+1)'(MAX_COLS)) n = (CW+1)'(MAX_COLS);
    else                                         n = (CW+1)'(cols_cfg);
  end
  assign last_col = CW'(n - 1'b1);

  always_comb begin
    for (int k = 0; k < WALL_W; k++) all_mask[k] = (k < int'(n));
  end

  // Final-row detect
  assign rows_eff = (rows_cfg == '0) ? (ROW_W+1)'(1) : {1'b0, rows_cfg};
  assign last_row = ({1'b0, row_cnt} + 1'b1) >= rows_eff;

  // Label compares against the current column and its right neighbor
  assign col1   = col + 1'b1;
  assign lab_j  = labels[col];
  assign lab_j1 = labels[col1];
  always_comb begin
    for (int k = 0; k < MAX_COLS; k++) begin
      eq_j[k]  = (labels[k] == lab_j)  && (k < int'(n));
      eq_j1[k] = (labels[k] == lab_j1) && (k < int'(n));
    end
  end

  always_comb begin
    other_exists = 1'b0;
    open_exists  = 1'b0;
    for (int k = 0; k < MAX_COLS; k++) begin
      if (eq_j[k] && (k != int'(col))) other_exists = 1'b1;
      if (eq_j[k] && !bw[k])          open_exists  = 1'b1;
    end
  end

  // Lowest label not in use
  always_comb begin
    free_lab = '0;
    for (int v = NUM_LABELS-1; v >= 0; v--) begin
      if (!used[v]) free_lab = LABEL_W'(v);
    end
  end

  assign restart = (cfg.valid && (cfg.index == REG_COLS || cfg.index == REG_ROWS)) ||
                   (cmd.emit && last_row);

  assign cfg.ready       = 1'b1;
  assign in_ch.ready     = in_ready;
  assign status.in_valid = in_ch.valid;
  assign status.last_row = last_row;
  assign status.out_free = !out_valid || out_ch.ready;
  assign out_ch.valid    = out_valid;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cols_cfg  <= COLS_W'(32);
      rows_cfg  <= ROW_W'(32);
      row_cnt   <= '0;
      for (int k = 0; k < MAX_COLS; k++) labels[k] <= LABEL_W'(k);
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cfg.valid) begin
        if (cfg.index == REG_COLS) cols_cfg <= cfg.data[COLS_W-1:0];
        if (cfg.index == REG_ROWS) rows_cfg <= cfg.data[ROW_W-1:0];
      end
      unique case (cmd.op)
        OP_RIGHT: begin
          if (col != last_col && !rr[col] && lab_j != lab_j1) begin
            for (int k = 0; k < MAX_COLS; k++) if (eq_j1[k]) labels[k] <= lab_j;
          end
        end
        OP_LAST: begin
          if (col != last_col && lab_j != lab_j1) begin
            for (int k = 0; k < MAX_COLS; k++) if (eq_j1[k]) labels[k] <= lab_j;
          end
        end
        OP_RELAB: begin
          if (bw[col]) labels[col] <= free_lab;
        end
        default: ;
      endcase
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (!last_row) row_cnt <= row_cnt + 1'b1;
      end
      if (restart) begin
        row_cnt <= '0;
        for (int k = 0; k < MAX_COLS; k++) labels[k] <= LABEL_W'(k);
      end
    end
  end

  // Row working registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rr   <= in_ch.right_random;
      br   <= in_ch.bottom_random;
      rw   <= '0;
      bw   <= '0;
      used <= '0;
    end
    unique case (cmd.op)
      OP_RIGHT: begin
        if (col != last_col && (rr[col] || lab_j == lab_j1)) rw[col] <= 1'b1;
      end
      OP_LAST: begin
        if (col != last_col && lab_j != lab_j1) rw[col] <= 1'b0;
      end
      OP_COUNT: bw[col] <= br[col] && other_exists;
      OP_OPEN:  if (!open_exists) bw[col] <= 1'b0;
      OP_USED:  if (!bw[col]) used[lab_j] <= 1'b1;
      OP_RELAB: if (bw[col]) used[free_lab] <= 1'b1;
      default: ;
    endcase
    if (cmd.emit) begin
      out_ch.right_walls  <= (rw | (WALL_W'(1) << last_col)) & all_mask;
      out_ch.bottom_walls <= last_row ? all_mask : (bw & all_mask);
      out_ch.row_number   <= row_cnt;
      out_ch.maze_done    <= last_row;
    end
  end
endmodule
`default_nettype wire

### sv/maze_row_generator_core.sv
// Maze row generator (Eller's scheme), one maze row per input beat.
// Channels: in_ch carries right_random/bottom_random, one random bit per
// column; out_ch returns right_walls, bottom_walls, row_number, maze_done.
// cfg writes register 0 (cols_in_use) or 1 (rows_in_use); any such write
// restarts the maze. cfg is always ready; the user must see that cfg is
// written only while idle; the block does not enforce it. The controller
// makes five left-to-right column passes (right walls, set count, opening
// check, label-use scan, relabel; a final row makes only the right-wall and
// join passes), one column per cycle, then waits in the emit state until
// the output register is free. The next beat can be accepted in the cycle
// after the emit, back in the idle state. One row is worked at a time;
// a new beat is accepted once the row's result is in the output register.
// Receiver stall: the output register holds its beat; a finished row waits
// in the emit state until the register frees up.
// Reset (rst, synchronous): labels take their column index, row counter
// clears, cols_in_use = rows_in_use = 32, output empty.
// Depends on mrg_pkg, the three channel interfaces, mrg_ctrl, mrg_datapath.
`default_nettype none
module maze_row_generator_core import mrg_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  mrg_row_in_if.sink    in_ch,
  mrg_row_out_if.source out_ch,
  mrg_cfg_if.sink       cfg
);
  localparam int CW = $clog2(MAX_COLS);

  mrg_cmd_t      cmd;
  mrg_status_t   status;
  logic [CW-1:0] col, last_col;
  logic          in_ready;

  mrg_ctrl #(.MAX_COLS(MAX_COLS)) u_ctrl (
    .clk(clk), .rst(rst), .status(status), .last_col(last_col),
    .cmd(cmd), .col(col), .in_ready(in_ready)
  );

  mrg_datapath #(.MAX_COLS(MAX_COLS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .col(col), .status(status),
    .last_col(last_col), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .in_ready(in_ready)
  );
endmodule
`default_nettype wire
